>>> sv/dll_pkg.sv
// ----------------------------------------------------------------------------
// dll_pkg
// Operation codes, decoded actions and sequencer states for the doubly
// linked list engine.
// ----------------------------------------------------------------------------
package dll_pkg;

  // Request operation codes
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_UNLINK     = 3'd4;

  // Action resolved when a request is accepted
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT,
    ACT_PUSH_BACK,
    ACT_TAKE_FRONT,
    ACT_TAKE_BACK,
    ACT_TAKE_MID,
    ACT_NULL
  } act_t;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_FIX  = 3'b100
  } state_t;

endpackage

>>> sv/doubly_linked_list_engine_top.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_top
// Doubly linked order over a pool of slots, links held in two link memories.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result shows on
// result_node, result_null and list_size for one cycle with done high, once
// the request has passed ST_EXEC, and cannot be held off. For pops and unlinks
// the slot's links are read from the link memories in the accept cycle and
// the neighbors are written back in ST_EXEC. A push onto a non-empty list
// also passes through ST_FIX, since it writes the same link memory twice
// through its single write port. A push onto an empty list and any request
// that changes nothing return to idle straight from ST_EXEC.
module doubly_linked_list_engine_top #(
  parameter int SLOTS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] operation,
  input  logic [5:0] node_index,
  input  logic       node_absent,
  output logic       done,
  output logic [5:0] result_node,
  output logic       result_null,
  output logic [6:0] list_size
);
  import dll_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW = $clog2(SLOTS + 1);
  localparam logic [SW-1:0] NIL = SW'(SLOTS);

  typedef logic [63:0][SW-1:0] mod_tbl_t;

  // Slot number of each request index, reduced modulo the pool size
  function automatic mod_tbl_t build_mod_tbl();
    mod_tbl_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = SW'(i % SLOTS);
    end
    return t;
  endfunction

  localparam mod_tbl_t MOD_TBL = build_mod_tbl();

  function automatic logic is_slot(logic [SW-1:0] v);
    return v < NIL;
  endfunction

  function automatic logic [SW-1:0] clamp(logic [SW-1:0] v);
    return (v < NIL) ? v : NIL;
  endfunction

  // Link memories
  logic [SW-1:0] next_mem [SLOTS];
  logic [SW-1:0] prev_mem [SLOTS];
  logic [SW-1:0] next_rd;
  logic [SW-1:0] prev_rd;

  state_t        state, state_next;
  act_t          act, act_dec;
  logic [SW-1:0] tgt, tgt_dec;
  logic [SW-1:0] head, head_next;
  logic [SW-1:0] tail, tail_next;
  logic [SW-1:0] count, count_next;

  logic          accept;
  logic [SW-1:0] slot_in;
  logic [SW-1:0] unlink_slot;

  logic          nwe, pwe;
  logic [IW-1:0] nwa, pwa;
  logic [SW-1:0] nwd, pwd;
  logic [SW-1:0] nx, pv;
  logic          out_null;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Resolve the request into an action and target slot
  always_comb begin
    slot_in     = MOD_TBL[node_index];
    unlink_slot = node_absent ? tail : slot_in;
    tgt_dec     = slot_in;
    unique case (operation)
      OP_PUSH_FRONT: act_dec = ACT_PUSH_FRONT;
      OP_PUSH_BACK:  act_dec = ACT_PUSH_BACK;
      OP_POP_FRONT: begin
        act_dec = (head == NIL) ? ACT_NULL : ACT_TAKE_FRONT;
        tgt_dec = head;
      end
      OP_POP_BACK: begin
        act_dec = (tail == NIL) ? ACT_NULL : ACT_TAKE_BACK;
        tgt_dec = tail;
      end
      OP_UNLINK: begin
        tgt_dec = unlink_slot;
        if (head == NIL) begin
          act_dec = ACT_NULL;
        end else if (unlink_slot == head) begin
          act_dec = ACT_TAKE_FRONT;
        end else if (unlink_slot == tail) begin
          act_dec = ACT_TAKE_BACK;
        end else begin
          act_dec = ACT_TAKE_MID;
        end
      end
      default:       act_dec = ACT_NULL;
    endcase
  end

  // Read both links of the target slot as the request is taken
  always_ff @(posedge clk) begin
    if (accept && is_slot(tgt_dec)) begin
      next_rd <= next_mem[tgt_dec[IW-1:0]];
      prev_rd <= prev_mem[tgt_dec[IW-1:0]];
    end
  end

  // Write back links, update head, tail and count
  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    nwe        = 1'b0;
    pwe        = 1'b0;
    nwa        = tgt[IW-1:0];
    pwa        = tgt[IW-1:0];
    nwd        = NIL;
    pwd        = NIL;
    nx         = clamp(next_rd);
    pv         = clamp(prev_rd);
    out_null   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        unique case (act)
          ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (count < NIL) count_next = count + 1'b1;
            nwe = 1'b1;
            pwe = 1'b1;
            if ((act == ACT_PUSH_FRONT) ? (head == NIL) : (tail == NIL)) begin
              head_next = tgt;
              tail_next = tgt;
            end else if (act == ACT_PUSH_FRONT) begin
              nwd        = head;
              pwa        = head[IW-1:0];
              pwd        = tgt;
              head_next  = tgt;
              state_next = ST_FIX;
            end else begin
              nwa        = tail[IW-1:0];
              nwd        = tgt;
              pwd        = tail;
              tail_next  = tgt;
              state_next = ST_FIX;
            end
          end
          ACT_TAKE_FRONT: begin
            if (count != '0) count_next = count - 1'b1;
            if (is_slot(nx)) begin
              pwe       = 1'b1;
              pwa       = nx[IW-1:0];
              head_next = nx;
            end else begin
              head_next = NIL;
              tail_next = NIL;
            end
          end
          ACT_TAKE_BACK: begin
            if (count != '0) count_next = count - 1'b1;
            if (is_slot(pv)) begin
              nwe       = 1'b1;
              nwa       = pv[IW-1:0];
              tail_next = pv;
            end else begin
              head_next = NIL;
              tail_next = NIL;
            end
          end
          ACT_TAKE_MID: begin
            if (count != '0) count_next = count - 1'b1;
            nwe = is_slot(pv);
            nwa = pv[IW-1:0];
            nwd = nx;
            pwe = is_slot(nx);
            pwa = nx[IW-1:0];
            pwd = pv;
          end
          ACT_NULL: begin
            out_null = 1'b1;
          end
          default: begin
            out_null = 1'b1;
          end
        endcase
      end
      ST_FIX: begin
        // Terminate the far link of the newly pushed slot
        state_next = ST_IDLE;
        if (act == ACT_PUSH_FRONT) begin
          pwe = 1'b1;
        end else begin
          nwe = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nwe) next_mem[nwa] <= nwd;
    if (pwe) prev_mem[pwa] <= pwd;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= NIL;
      tail  <= NIL;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      done  <= (state == ST_EXEC);
    end
  end

  // Latch the request and the result transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      act <= act_dec;
      tgt <= tgt_dec;
    end
    if (state == ST_EXEC) begin
      result_node <= out_null ? 6'd0 : 6'(tgt);
      result_null <= out_null;
      list_size   <= 7'(count_next);
    end
  end

  // Checks
  a_exec_done : assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC |=> done)
    else $error("result strobe missing after execute");

  a_done_src : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_EXEC)
    else $error("result strobe without execute");

  a_count_max : assert property (@(posedge clk) disable iff (rst)
    count <= NIL)
    else $error("count above pool size");

  a_ends_nil : assert property (@(posedge clk) disable iff (rst)
    (head == NIL) == (tail == NIL))
    else $error("head and tail disagree on empty list");

  a_idle_quiet : assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !nwe && !pwe)
    else $error("link write while idle");

endmodule
